FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers, disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define QRG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// condition must never be true at a clock edge outside reset
`define QRG_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

FILE: rtl/qrg_pkg.sv
// ----------------------------------------------------------------------------
// qrg_pkg
// Shared types and constants of the qubit rotation gate update.
// ----------------------------------------------------------------------------
package qrg_pkg;

    localparam int ANGLE_STEPS_DEF   = 100;
    localparam int AMP_FRAC_BITS_DEF = 14;

    localparam int AMP_W       = 16;
    localparam int PHASE_W     = 7;
    localparam int PHASE_DEPTH = 1 << PHASE_W;
    localparam int TRIG_BITS   = 28;
    localparam int TRIG_W      = 32;

    localparam bit [63:0] PI_Q28 = 64'd843314857;

    typedef logic signed [AMP_W-1:0]  t_amp;
    typedef logic        [PHASE_W-1:0] t_phase;

    typedef struct packed {
        logic signed [TRIG_W-1:0] sin_v;
        logic signed [TRIG_W-1:0] cos_v;
    } t_trig;

endpackage

FILE: rtl/qrg_trig_rom.sv
// ----------------------------------------------------------------------------
// qrg_trig_rom
// Constant sin/cos table of the step angle pi/(ANGLE_STEPS + phase), Q28,
// built at elaboration from a 13-term Taylor series.
// ----------------------------------------------------------------------------
module qrg_trig_rom #(
    parameter int ANGLE_STEPS = qrg_pkg::ANGLE_STEPS_DEF
) (
    input  qrg_pkg::t_phase i_phase,
    output qrg_pkg::t_trig  o_trig
);
    import qrg_pkg::*;

    t_trig w_tab [PHASE_DEPTH];

    for (genvar gp = 0; gp < PHASE_DEPTH; gp++) begin : g_entry
        localparam bit [63:0] D   = 64'(ANGLE_STEPS) + 64'(gp);
        localparam bit [63:0] X   = (PI_Q28 + D / 2) / D;
        localparam bit [63:0] X2  = (X * X) >> TRIG_BITS;
        localparam bit [63:0] TS1  = ((X    * X2) >> TRIG_BITS) / (2 * 3);
        localparam bit [63:0] TS2  = ((TS1  * X2) >> TRIG_BITS) / (4 * 5);
        localparam bit [63:0] TS3  = ((TS2  * X2) >> TRIG_BITS) / (6 * 7);
        localparam bit [63:0] TS4  = ((TS3  * X2) >> TRIG_BITS) / (8 * 9);
        localparam bit [63:0] TS5  = ((TS4  * X2) >> TRIG_BITS) / (10 * 11);
        localparam bit [63:0] TS6  = ((TS5  * X2) >> TRIG_BITS) / (12 * 13);
        localparam bit [63:0] TS7  = ((TS6  * X2) >> TRIG_BITS) / (14 * 15);
        localparam bit [63:0] TS8  = ((TS7  * X2) >> TRIG_BITS) / (16 * 17);
        localparam bit [63:0] TS9  = ((TS8  * X2) >> TRIG_BITS) / (18 * 19);
        localparam bit [63:0] TS10 = ((TS9  * X2) >> TRIG_BITS) / (20 * 21);
        localparam bit [63:0] TS11 = ((TS10 * X2) >> TRIG_BITS) / (22 * 23);
        localparam bit [63:0] TS12 = ((TS11 * X2) >> TRIG_BITS) / (24 * 25);
        localparam bit [63:0] TC0  = 64'd1 << TRIG_BITS;
        localparam bit [63:0] TC1  = ((TC0  * X2) >> TRIG_BITS) / (1 * 2);
        localparam bit [63:0] TC2  = ((TC1  * X2) >> TRIG_BITS) / (3 * 4);
        localparam bit [63:0] TC3  = ((TC2  * X2) >> TRIG_BITS) / (5 * 6);
        localparam bit [63:0] TC4  = ((TC3  * X2) >> TRIG_BITS) / (7 * 8);
        localparam bit [63:0] TC5  = ((TC4  * X2) >> TRIG_BITS) / (9 * 10);
        localparam bit [63:0] TC6  = ((TC5  * X2) >> TRIG_BITS) / (11 * 12);
        localparam bit [63:0] TC7  = ((TC6  * X2) >> TRIG_BITS) / (13 * 14);
        localparam bit [63:0] TC8  = ((TC7  * X2) >> TRIG_BITS) / (15 * 16);
        localparam bit [63:0] TC9  = ((TC8  * X2) >> TRIG_BITS) / (17 * 18);
        localparam bit [63:0] TC10 = ((TC9  * X2) >> TRIG_BITS) / (19 * 20);
        localparam bit [63:0] TC11 = ((TC10 * X2) >> TRIG_BITS) / (21 * 22);
        localparam bit [63:0] TC12 = ((TC11 * X2) >> TRIG_BITS) / (23 * 24);
        localparam bit [63:0] S = X - TS1 + TS2 - TS3 + TS4 - TS5 + TS6
                                  - TS7 + TS8 - TS9 + TS10 - TS11 + TS12;
        localparam bit [63:0] C = TC0 - TC1 + TC2 - TC3 + TC4 - TC5 + TC6
                                  - TC7 + TC8 - TC9 + TC10 - TC11 + TC12;

        assign w_tab[gp].sin_v = S[TRIG_W-1:0];
        assign w_tab[gp].cos_v = C[TRIG_W-1:0];
    end

    assign o_trig = w_tab[i_phase];

endmodule

FILE: rtl/qrg_direction.sv
// ----------------------------------------------------------------------------
// qrg_direction
// Picks the rotation direction from the current and best qubit angles by
// sign-aware cross-multiplication; a zero amplitude defers to the random bit.
// ----------------------------------------------------------------------------
module qrg_direction (
    input  qrg_pkg::t_amp i_amp_a,
    input  qrg_pkg::t_amp i_amp_b,
    input  qrg_pkg::t_amp i_best_amp_a,
    input  qrg_pkg::t_amp i_best_amp_b,
    input  logic          i_random_direction,
    output logic          o_positive,
    output logic          o_degenerate
);
    import qrg_pkg::*;

    logic signed [2*AMP_W-1:0] w_prod_cur;
    logic signed [2*AMP_W-1:0] w_prod_best;
    logic signed [2*AMP_W:0]   w_num;
    logic                      w_a_pos;
    logic                      w_b_pos;
    logic                      w_ba_pos;
    logic                      w_bb_pos;
    logic                      w_xi_pos;
    logic                      w_xib_pos;
    logic                      w_same_a;
    logic                      w_cmp;

    assign w_prod_cur  = i_best_amp_b * i_amp_a;
    assign w_prod_best = i_amp_b * i_best_amp_a;
    assign w_num       = (2*AMP_W+1)'(w_prod_cur) - (2*AMP_W+1)'(w_prod_best);

    assign o_degenerate = (i_amp_a == '0) || (i_amp_b == '0) ||
                          (i_best_amp_a == '0) || (i_best_amp_b == '0);

    assign w_a_pos   = !i_amp_a[AMP_W-1];
    assign w_b_pos   = !i_amp_b[AMP_W-1];
    assign w_ba_pos  = !i_best_amp_a[AMP_W-1];
    assign w_bb_pos  = !i_best_amp_b[AMP_W-1];
    assign w_xi_pos  = (w_a_pos == w_b_pos);
    assign w_xib_pos = (w_ba_pos == w_bb_pos);
    assign w_same_a  = (w_a_pos == w_ba_pos);

    always_comb begin
        if (w_same_a) begin
            w_cmp = !w_num[2*AMP_W];
        end else begin
            w_cmp = w_num[2*AMP_W] || (w_num == '0);
        end
    end

    always_comb begin
        if (o_degenerate) begin
            o_positive = i_random_direction;
        end else if (w_xi_pos == w_xib_pos) begin
            o_positive = w_cmp;
        end else if (w_xib_pos) begin
            o_positive = w_same_a;
        end else begin
            o_positive = !w_same_a;
        end
    end

endmodule

FILE: rtl/qubit_rotation_gate_update.sv
// ----------------------------------------------------------------------------
// qubit_rotation_gate_update
// Registers: input reg, then result reg, between input accept and result valid.
// Throughput: one item per cycle while the output is not stalled; the single pass
// through table, four 16x32 multipliers and the round/saturate adder sets the cycle.
// Reset: synchronous active low; clears both valid flags, payload not reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qubit_rotation_gate_update #(
    parameter int ANGLE_STEPS   = qrg_pkg::ANGLE_STEPS_DEF,
    parameter int AMP_FRAC_BITS = qrg_pkg::AMP_FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // amp_a, amp_b, best_amp_a, best_amp_b, generation_phase, zero pad
    input  logic [71:0] i_s_tdata,
    // random_direction
    input  logic        i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // new_amp_a, new_amp_b
    output logic [31:0] o_m_tdata,
    // turned_positive
    output logic        o_m_tuser
);
    import qrg_pkg::*;

    localparam int     SUM_W = AMP_W + TRIG_W + 1;
    localparam longint ONE   = longint'(1) << AMP_FRAC_BITS;
    localparam longint HI    = (ONE < 32767) ? ONE : 32767;
    localparam longint LO    = (-ONE > -32768) ? -ONE : -32768;
    localparam logic signed [SUM_W-1:0] SAT_HI   = SUM_W'(HI);
    localparam logic signed [SUM_W-1:0] SAT_LO   = SUM_W'(LO);
    localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1) << (TRIG_BITS - 1);

    logic   r_in_valid;
    t_amp   r_in_a;
    t_amp   r_in_b;
    t_amp   r_in_ba;
    t_amp   r_in_bb;
    t_phase r_in_phase;
    logic   r_in_rnd;

    logic   r_out_valid;
    t_amp   r_out_a;
    t_amp   r_out_b;
    logic   r_out_pos;

    logic   w_s_acc;
    logic   w_adv;
    logic   w_pos;
    logic   w_degen;
    t_trig  w_trig;

    logic signed [AMP_W+TRIG_W-1:0] w_ac;
    logic signed [AMP_W+TRIG_W-1:0] w_bs;
    logic signed [AMP_W+TRIG_W-1:0] w_as;
    logic signed [AMP_W+TRIG_W-1:0] w_bc;
    logic signed [SUM_W-1:0]        w_ra;
    logic signed [SUM_W-1:0]        w_rb;
    t_amp                           n_out_a;
    t_amp                           n_out_b;

    function automatic t_amp round_sat(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] r;
        r = (v + RND_HALF) >>> TRIG_BITS;
        if (r > SAT_HI) begin
            return SAT_HI[AMP_W-1:0];
        end else if (r < SAT_LO) begin
            return SAT_LO[AMP_W-1:0];
        end
        return r[AMP_W-1:0];
    endfunction

    assign w_adv      = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_adv;
    assign w_s_acc    = i_s_tvalid && o_s_tready;

    qrg_trig_rom #(
        .ANGLE_STEPS(ANGLE_STEPS)
    ) u_trig_rom (
        .i_phase(r_in_phase),
        .o_trig (w_trig)
    );

    qrg_direction u_direction (
        .i_amp_a           (r_in_a),
        .i_amp_b           (r_in_b),
        .i_best_amp_a      (r_in_ba),
        .i_best_amp_b      (r_in_bb),
        .i_random_direction(r_in_rnd),
        .o_positive        (w_pos),
        .o_degenerate      (w_degen)
    );

    assign w_ac = r_in_a * w_trig.cos_v;
    assign w_bs = r_in_b * w_trig.sin_v;
    assign w_as = r_in_a * w_trig.sin_v;
    assign w_bc = r_in_b * w_trig.cos_v;

    always_comb begin
        if (w_pos) begin
            w_ra = SUM_W'(w_ac) - SUM_W'(w_bs);
            w_rb = SUM_W'(w_bc) + SUM_W'(w_as);
        end else begin
            w_ra = SUM_W'(w_ac) + SUM_W'(w_bs);
            w_rb = SUM_W'(w_bc) - SUM_W'(w_as);
        end
    end

    assign n_out_a = round_sat(w_ra);
    assign n_out_b = round_sat(w_rb);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_s_acc) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_in_a     <= i_s_tdata[15:0];
            r_in_b     <= i_s_tdata[31:16];
            r_in_ba    <= i_s_tdata[47:32];
            r_in_bb    <= i_s_tdata[63:48];
            r_in_phase <= i_s_tdata[70:64];
            r_in_rnd   <= i_s_tuser;
        end
        if (w_adv) begin
            r_out_a   <= n_out_a;
            r_out_b   <= n_out_b;
            r_out_pos <= w_pos;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_b, r_out_a};
    assign o_m_tuser  = r_out_pos;

    `QRG_ASSERT(a_adv_fills_out, (r_in_valid && w_adv) |=> r_out_valid, "item lost in advance")
    `QRG_ASSERT(a_degen_random, (w_adv && w_degen) |=> (o_m_tuser == $past(r_in_rnd)), "bad dir")
    `QRG_NEVER(a_out_range, o_m_tvalid && (r_out_a > SAT_HI || r_out_a < SAT_LO), "a sat")
    `QRG_NEVER(a_out_range_b, o_m_tvalid && (r_out_b > SAT_HI || r_out_b < SAT_LO), "b sat")
    `QRG_ASSERT(a_ready_empty, !r_in_valid |-> o_s_tready, "stalled while empty")

endmodule
